// ===== rtl/sos_pkg.sv =====
// ----------------------------------------------------------------------------
// sos_pkg: shared types and constants of the servo sine oscillator
// Field widths, register codes, state encoding, divider request/response
// structs and the quarter-wave sine table built at elaboration.
// ----------------------------------------------------------------------------
package sos_pkg;

  // sine generator sizing
  localparam int unsigned SINE_ENTRIES = 256;
  localparam int unsigned PHASE_BITS   = 32;
  localparam int unsigned SINE_IDX_W   = $clog2(SINE_ENTRIES);
  localparam int unsigned SINE_W       = 17;
  localparam int unsigned SINE_FRAC    = 16;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  // field widths
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned NOW_W    = 32;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned DUTY_W   = 10;
  localparam int unsigned AMP_W    = 7;
  localparam int unsigned OFS_W    = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned SPER_W   = 10;
  localparam int unsigned START_W  = 16;
  localparam int unsigned TRIM_W   = 8;
  localparam int unsigned SLEW_W   = 14;
  localparam int unsigned MODE_W   = 2;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register reset values
  localparam int unsigned AMP_RESET    = 45;
  localparam int unsigned PERIOD_RESET = 2000;
  localparam int unsigned SPER_RESET   = 30;
  localparam int unsigned POS_RESET    = 90;

  // mode bits
  localparam int unsigned MODE_REVERSE = 0;
  localparam int unsigned MODE_PAUSE   = 1;

  // position and duty arithmetic
  localparam int unsigned PW          = POS_W + 1;
  localparam int unsigned RND_W       = AMP_W + SINE_W - SINE_FRAC + 1;
  localparam int unsigned POS_CENTER  = 90;
  localparam int unsigned POS_MAX     = 180;
  localparam int unsigned CLAMP_W     = 8;
  localparam int unsigned DUTY_X_W    = 10;
  localparam int unsigned DUTY_BIAS   = 180;
  localparam int unsigned DUTY_SHIFT  = 13;
  localparam int unsigned DUTY_NUM_W  = DUTY_X_W + DUTY_SHIFT;
  localparam int unsigned DUTY_DEN    = 7200;
  localparam int unsigned MS_PER_S    = 1000;

  // serial multiplier: 32-bit multiplicand, one multiplier bit per cycle
  localparam int unsigned MUL_A_W   = NOW_W;
  localparam int unsigned MUL_B_W   = SLEW_W;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_B_W);

  // serial divider: one quotient bit per cycle
  localparam int unsigned DIV_NUM_W = (PHASE_BITS + 1 > PROD_W) ? PHASE_BITS + 1 : PROD_W;
  localparam int unsigned DIV_DEN_W = PERIOD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam int unsigned NS_STEPS   = PERIOD_W;
  localparam int unsigned INC_STEPS  = PHASE_BITS + 1;
  localparam int unsigned SLEW_STEPS = DIV_NUM_W;
  localparam int unsigned DUTY_STEPS = DUTY_NUM_W;

  typedef enum logic [1:0] {
    OP_TICK        = 2'd0,
    OP_WRITE       = 2'd1,
    OP_PHASE_RESET = 2'd2
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AMPLITUDE     = 3'd0,
    CFG_CENTER_OFFSET = 3'd1,
    CFG_PERIOD        = 3'd2,
    CFG_SAMPLE_PERIOD = 3'd3,
    CFG_START_PHASE   = 3'd4,
    CFG_TRIM          = 3'd5,
    CFG_SLEW_LIMIT    = 3'd6,
    CFG_MODE          = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_NS_DIV,
    ST_INC_DIV,
    ST_SIN_MUL,
    ST_SIN_RND,
    ST_WRITE,
    ST_SLEW_MUL,
    ST_SLEW_DIV,
    ST_DUTY,
    ST_DUTY_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } div_rsp_t;

  typedef logic [SINE_W-1:0] sine_tab_t [SINE_ENTRIES];

  // one table entry: Taylor series of sin in Q30, rounded to Q16
  function automatic logic [SINE_W-1:0] sine_entry(int unsigned k);
    longint unsigned x;
    longint unsigned s;
    longint unsigned t;
    x = (64'(k) * PI_HALF_Q30) / SINE_ENTRIES;
    s = x;
    t = x;
    for (int n = 1; n <= 7; n++) begin
      t = (((t * x) >> 30) * x) >> 30;
      t = t / 64'((2 * n) * (2 * n + 1));
      if (n[0]) s = s - t;
      else s = s + t;
    end
    return SINE_W'((s + 64'd8192) >> 14);
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      tab[k] = sine_entry(k);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();
  localparam logic [SINE_W-1:0] SINE_TOP = sine_entry(SINE_ENTRIES);

endpackage

// ===== rtl/servo_sine_oscillator_top.sv =====
// ----------------------------------------------------------------------------
// servo_sine_oscillator_top: sine oscillator driving a servo with slew limit
// Ticks take sine samples, direct words command the position, and every
// write yields a new 10-bit PWM compare value.
// ----------------------------------------------------------------------------
// One word is in work at a time; the next word is taken as soon as the
// previous result sits in the output register. A phase reset, an unknown
// opcode or a tick with no sample due goes from decode straight to the
// completion state. The rest is set by one shared bit-serial divider (one
// quotient bit per cycle) and a shift-add multiplier (one multiplier bit per
// cycle): a direct write runs the duty division, after the slew product and
// division when the slew limiter is on; a due tick first runs the two
// phase-increment divisions and, unless paused, the sine product before it
// writes. A paused tick ends after the two divisions.
module servo_sine_oscillator_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic        [sos_pkg::OPCODE_W-1:0] in_opcode_i,
  input  logic        [sos_pkg::NOW_W-1:0]    in_now_ms_i,
  input  logic signed [sos_pkg::POS_W-1:0]    in_target_position_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic        [sos_pkg::DUTY_W-1:0]   out_duty_o,
  output logic signed [sos_pkg::POS_W-1:0]    out_position_o,
  output logic                               out_written_o,
  input  logic                               cfg_we_i,
  input  logic        [sos_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic        [sos_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sos_pkg::*;

  // configuration
  logic        [AMP_W-1:0]    amp_q;
  logic signed [OFS_W-1:0]    ofs_q;
  logic        [PERIOD_W-1:0] period_q;
  logic        [SPER_W-1:0]   sper_q;
  logic        [START_W-1:0]  start_q;
  logic signed [TRIM_W-1:0]   trim_q;
  logic        [SLEW_W-1:0]   slew_q;
  logic        [MODE_W-1:0]   mode_q;

  // block state
  state_e                     state_q, state_d;
  logic        [PHASE_BITS-1:0] phase_q;
  logic        [NOW_W-1:0]    last_sample_q;
  logic        [NOW_W-1:0]    last_cmd_q;
  logic signed [POS_W-1:0]    pos_q;
  logic        [DUTY_W-1:0]   held_duty_q;

  // current word
  logic        [OPCODE_W-1:0] op_q;
  logic        [NOW_W-1:0]    now_q;
  logic signed [POS_W-1:0]    tgt_q;
  logic                       wr_q;
  logic        [PHASE_BITS-1:0] ph_q;
  logic signed [POS_W-1:0]    wtgt_q;

  // serial multiplier
  logic        [MUL_A_W-1:0]  mcand_q;
  logic        [PROD_W-1:0]   prod_q;
  logic        [MUL_CNT_W-1:0] mcnt_q;
  logic                       sneg_q;

  // output register
  logic                       out_valid_q;
  logic        [DUTY_W-1:0]   out_duty_q;
  logic signed [POS_W-1:0]    out_pos_q;
  logic                       out_wr_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                       in_accept;
  logic                       out_free;
  logic                       out_load;
  logic        [NOW_W-1:0]    elapsed_smp;
  logic        [NOW_W-1:0]    elapsed_cmd;
  logic                       due;
  logic        [SPER_W-1:0]   sp1;
  logic        [PERIOD_W-1:0] ns_c;
  logic        [PERIOD_W-1:0] ns1;
  logic        [PHASE_BITS-1:0] inc_c;
  logic        [1:0]          quad_c;
  logic        [SINE_IDX_W-1:0] idx_c;
  logic        [SINE_IDX_W-1:0] lut_idx;
  logic        [SINE_W-1:0]   sine_mag;
  logic                       mbit;
  logic        [MUL_A_W:0]    msum;
  logic        [PROD_W-1:0]   prod_step;
  logic                       mul_last;
  logic        [PROD_W-1:0]   rnd_c;
  logic        [RND_W-1:0]    r_c;
  logic signed [PW-1:0]       samp_c;
  logic signed [PW-1:0]       p_c;
  logic signed [PW-1:0]       pr_c;
  logic signed [PW-1:0]       tgt_sum;
  logic signed [PW-1:0]       diff_c;
  logic        [PW-1:0]       adiff;
  logic        [DIV_NUM_W-1:0] lim1;
  logic                       over_c;
  logic        [PW-1:0]       moved;
  logic signed [POS_W-1:0]    pos_slew;
  logic signed [PW-1:0]       a_c;
  logic        [CLAMP_W-1:0]  a_cl;
  logic        [DUTY_X_W-1:0] x_c;
  logic        [DUTY_NUM_W-1:0] duty_num;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // sample timing and phase increment operands
  assign elapsed_smp = now_q - last_sample_q;
  assign elapsed_cmd = now_q - last_cmd_q;
  assign due         = elapsed_smp > NOW_W'(sper_q);
  assign sp1         = (sper_q == '0) ? SPER_W'(1) : sper_q;
  assign ns_c        = div_rsp.quotient[PERIOD_W-1:0];
  assign ns1         = (ns_c == '0) ? PERIOD_W'(1) : ns_c;
  assign inc_c       = div_rsp.quotient[PHASE_BITS-1:0];

  // quarter-wave lookup; odd quadrants read the table mirrored
  assign quad_c   = ph_q[PHASE_BITS-1 -: 2];
  assign idx_c    = ph_q[PHASE_BITS-3 -: SINE_IDX_W];
  assign lut_idx  = quad_c[0] ? (SINE_IDX_W'(0) - idx_c) : idx_c;
  assign sine_mag = (quad_c[0] && (idx_c == '0)) ? SINE_TOP : SINE_TAB[lut_idx];

  // shift-add step: add multiplicand into the high half, shift right
  assign mbit      = prod_q[0];
  assign msum      = {1'b0, prod_q[PROD_W-1:MUL_B_W]} + (mbit ? {1'b0, mcand_q} : '0);
  assign prod_step = {msum, prod_q[MUL_B_W-1:1]};
  assign mul_last  = (mcnt_q == MUL_CNT_W'(MUL_B_W - 1));

  // round the sine product half away from zero, then offset and center
  assign rnd_c   = prod_q + PROD_W'(1 << (SINE_FRAC - 1));
  assign r_c     = rnd_c[SINE_FRAC +: RND_W];
  assign samp_c  = sneg_q ? -$signed(PW'(r_c)) : $signed(PW'(r_c));
  assign p_c     = samp_c + PW'(ofs_q);
  assign pr_c    = mode_q[MODE_REVERSE] ? -p_c : p_c;
  assign tgt_sum = pr_c + $signed(PW'(POS_CENTER));

  // slew limiter
  assign diff_c   = PW'(wtgt_q) - PW'(pos_q);
  assign adiff    = diff_c[PW-1] ? PW'(-diff_c) : PW'(diff_c);
  assign lim1     = (div_rsp.quotient == '0) ? DIV_NUM_W'(1) : div_rsp.quotient;
  assign over_c   = DIV_NUM_W'(adiff) > lim1;
  assign moved    = diff_c[PW-1] ? (PW'(pos_q) - lim1[PW-1:0]) : (PW'(pos_q) + lim1[PW-1:0]);
  assign pos_slew = over_c ? moved[POS_W-1:0] : wtgt_q;

  // duty = (4a + 180) * 8191 / 7200 with a clamped to 0..180
  assign a_c = PW'(pos_q) + PW'(trim_q);
  always_comb begin
    if (a_c < 0) begin
      a_cl = '0;
    end else if (a_c > $signed(PW'(POS_MAX))) begin
      a_cl = CLAMP_W'(POS_MAX);
    end else begin
      a_cl = a_c[CLAMP_W-1:0];
    end
  end
  assign x_c      = (DUTY_X_W'(a_cl) << 2) + DUTY_X_W'(DUTY_BIAS);
  assign duty_num = (DUTY_NUM_W'(x_c) << DUTY_SHIFT) - DUTY_NUM_W'(x_c);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (op_q)
          OP_TICK:  state_d = due ? ST_NS_DIV : ST_DONE;
          OP_WRITE: state_d = ST_WRITE;
          default:  state_d = ST_DONE;
        endcase
      end
      ST_NS_DIV: begin
        if (div_rsp.done) state_d = ST_INC_DIV;
      end
      ST_INC_DIV: begin
        if (div_rsp.done) state_d = mode_q[MODE_PAUSE] ? ST_DONE : ST_SIN_MUL;
      end
      ST_SIN_MUL: begin
        if (mul_last) state_d = ST_SIN_RND;
      end
      ST_SIN_RND: state_d = ST_WRITE;
      ST_WRITE: begin
        state_d = (slew_q != '0) ? ST_SLEW_MUL : ST_DUTY;
      end
      ST_SLEW_MUL: begin
        if (mul_last) state_d = ST_SLEW_DIV;
      end
      ST_SLEW_DIV: begin
        if (div_rsp.done) state_d = ST_DUTY;
      end
      ST_DUTY: state_d = ST_DUTY_DIV;
      ST_DUTY_DIV: begin
        if (div_rsp.done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs: divider launches and output register load
  always_comb begin
    div_req  = '0;
    out_load = 1'b0;
    case (state_q)
      ST_DECODE: begin
        if ((op_q == OP_TICK) && due) begin
          div_req.start    = 1'b1;
          div_req.steps    = DIV_CNT_W'(NS_STEPS);
          div_req.dividend = DIV_NUM_W'(period_q) << (DIV_NUM_W - PERIOD_W);
          div_req.divisor  = DIV_DEN_W'(sp1);
        end
      end
      ST_NS_DIV: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.steps    = DIV_CNT_W'(INC_STEPS);
          div_req.dividend = DIV_NUM_W'(1) << (DIV_NUM_W - 1);
          div_req.divisor  = DIV_DEN_W'(ns1);
        end
      end
      ST_SLEW_MUL: begin
        if (mul_last) begin
          div_req.start    = 1'b1;
          div_req.steps    = DIV_CNT_W'(SLEW_STEPS);
          div_req.dividend = DIV_NUM_W'(prod_step);
          div_req.divisor  = DIV_DEN_W'(MS_PER_S);
        end
      end
      ST_DUTY: begin
        div_req.start    = 1'b1;
        div_req.steps    = DIV_CNT_W'(DUTY_STEPS);
        div_req.dividend = DIV_NUM_W'(duty_num) << (DIV_NUM_W - DUTY_NUM_W);
        div_req.divisor  = DIV_DEN_W'(DUTY_DEN);
      end
      ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  sos_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // control, configuration and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      amp_q         <= AMP_W'(AMP_RESET);
      ofs_q         <= '0;
      period_q      <= PERIOD_W'(PERIOD_RESET);
      sper_q        <= SPER_W'(SPER_RESET);
      start_q       <= '0;
      trim_q        <= '0;
      slew_q        <= '0;
      mode_q        <= '0;
      phase_q       <= '0;
      last_sample_q <= '0;
      last_cmd_q    <= '0;
      pos_q         <= POS_W'(POS_RESET);
      held_duty_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_AMPLITUDE:     amp_q    <= cfg_data_i[AMP_W-1:0];
          CFG_CENTER_OFFSET: ofs_q    <= cfg_data_i[OFS_W-1:0];
          CFG_PERIOD:        period_q <= cfg_data_i[PERIOD_W-1:0];
          CFG_SAMPLE_PERIOD: sper_q   <= cfg_data_i[SPER_W-1:0];
          CFG_START_PHASE:   start_q  <= cfg_data_i[START_W-1:0];
          CFG_TRIM:          trim_q   <= cfg_data_i[TRIM_W-1:0];
          CFG_SLEW_LIMIT:    slew_q   <= cfg_data_i[SLEW_W-1:0];
          CFG_MODE:          mode_q   <= cfg_data_i[MODE_W-1:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_DECODE: begin
          if ((op_q == OP_TICK) && due) last_sample_q <= now_q;
          if (op_q == OP_PHASE_RESET) phase_q <= '0;
        end
        ST_INC_DIV: begin
          if (div_rsp.done) phase_q <= phase_q + inc_c;
        end
        ST_WRITE: begin
          if (slew_q == '0) begin
            pos_q      <= wtgt_q;
            last_cmd_q <= now_q;
          end
        end
        ST_SLEW_DIV: begin
          if (div_rsp.done) begin
            pos_q      <= pos_slew;
            last_cmd_q <= now_q;
          end
        end
        ST_DUTY_DIV: begin
          if (div_rsp.done) held_duty_q <= div_rsp.quotient[DUTY_W-1:0];
        end
        default: ;
      endcase
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= in_opcode_i;
      now_q <= in_now_ms_i;
      tgt_q <= in_target_position_i;
      wr_q  <= 1'b0;
    end
    case (state_q)
      ST_DECODE: begin
        // sample phase uses the accumulator before this tick advances it
        ph_q   <= phase_q + (PHASE_BITS'(start_q) << (PHASE_BITS - START_W));
        wtgt_q <= tgt_q;
      end
      ST_INC_DIV: begin
        if (div_rsp.done) begin
          mcand_q <= MUL_A_W'(sine_mag);
          prod_q  <= PROD_W'(amp_q);
          mcnt_q  <= '0;
          sneg_q  <= quad_c[1];
        end
      end
      ST_SIN_MUL, ST_SLEW_MUL: begin
        prod_q <= prod_step;
        mcnt_q <= mcnt_q + MUL_CNT_W'(1);
      end
      ST_SIN_RND: wtgt_q <= tgt_sum[POS_W-1:0];
      ST_WRITE: begin
        mcand_q <= elapsed_cmd;
        prod_q  <= PROD_W'(slew_q);
        mcnt_q  <= '0;
      end
      ST_DUTY_DIV: begin
        if (div_rsp.done) wr_q <= 1'b1;
      end
      ST_DONE: begin
        if (out_load) begin
          out_duty_q <= held_duty_q;
          out_pos_q  <= pos_q;
          out_wr_q   <= wr_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign out_duty_o     = out_duty_q;
  assign out_position_o = out_pos_q;
  assign out_written_o  = out_wr_q;

  // divider is launched only when free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider launched while busy");

  // no division left running once the word is finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while idle");

  // a result word appears only out of the completion state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result word raised outside completion");

endmodule

// ===== rtl/sos_div.sv =====
// ----------------------------------------------------------------------------
// sos_div: bit-serial restoring divider
// Shifts the left-aligned dividend in one bit per cycle and builds the
// quotient one bit per cycle for the requested number of steps.
// ----------------------------------------------------------------------------
module sos_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sos_pkg::div_req_t req_i,
  output sos_pkg::div_rsp_t rsp_o
);
  import sos_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_NUM_W-1:0] num_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W-1:0] rem_q;

  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  assign trial = {rem_q, num_q[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // flag the cycle after the last quotient bit
      done_q <= busy_q && !req_i.start && (cnt_q == DIV_CNT_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      den_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== sim/tb_servo_sine_oscillator_top.sv =====
// ----------------------------------------------------------------------------
// tb_servo_sine_oscillator_top: self-checking bench of the servo oscillator
// A directed table of words and register writes runs first, then randomized
// phases of ticks, direct writes, phase resets and unknown opcodes. A behavioral
// servo model predicts every result word the table does not give, and each
// expected word is compared field by field on output.
`timescale 1ns / 1ps

module tb_servo_sine_oscillator_top;
  import sos_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNKNOWN = 2'd3;
  localparam int unsigned QTR = SINE_ENTRIES;

  typedef struct {
    logic        [DUTY_W-1:0] duty;
    logic signed [POS_W-1:0]  pos;
    logic                     written;
  } servo_word_t;

  typedef struct {
    int amp;
    int ofs;
    int period;
    int spacing;
    int phase0;
    int trim;
    int slew;
    int mode;
  } servo_cfg_t;

  typedef enum {ROW_WORD, ROW_REG} row_kind_e;
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_style_e;

  typedef struct {
    row_kind_e     kind;
    cfg_idx_e      idx;
    logic [1:0]    op;
    logic [31:0]   now;
    int            val;
    bit            given;
    int            duty;
    int            pos;
    bit            wr;
  } row_t;

  // DUT ports
  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic        [OPCODE_W-1:0]   in_opcode_i = '0;
  logic        [NOW_W-1:0]      in_now_ms_i = '0;
  logic signed [POS_W-1:0]      in_target_position_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic        [DUTY_W-1:0]     out_duty_o;
  logic signed [POS_W-1:0]      out_position_o;
  logic                         out_written_o;
  logic                         cfg_we_i = 1'b0;
  logic        [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic        [CFG_DATA_W-1:0] cfg_data_i = '0;

  // servo model: settings
  int unsigned amp_deg, period_ms, sample_ms, start_turn, slew_dps;
  int          ofs_deg, trim_deg;
  logic [1:0]  mode_cfg;
  // servo model: state
  int          sine_q16 [0:QTR];
  logic [31:0] phase_acc, last_sample_ms, last_cmd_ms;
  int          pos_deg;
  logic [9:0]  duty_held;

  servo_word_t servo_q [$];
  logic [31:0] clock_ms = 32'd2000;
  int errors = 0, words_sent = 0, results_checked = 0, settings_loaded = 0;
  int samples_taken = 0, samples_paused = 0, direct_writes = 0, phase_resets = 0;

  rx_style_e   rx_style = RX_OPEN;
  int          rx_hold = 0;
  logic [3:0]  rx_tick = '0;

  row_t plan [34] = '{
    '{ROW_WORD, CFG_AMPLITUDE,     OP_UNKNOWN,     32'd0,          0, 1'b1,    0,   90, 1'b0},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_PHASE_RESET, 32'd5,          0, 1'b1,    0,   90, 1'b0},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_TICK,        32'd30,         0, 1'b1,    0,   90, 1'b0},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_TICK,        32'd31,         0, 1'b1,  614,   90, 1'b1},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_WRITE,       32'd40,       180, 1'b1, 1023,  180, 1'b1},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_WRITE,       32'd41,         0, 1'b1,  204,    0, 1'b1},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_WRITE,       32'd42,      -180, 1'b1,  204, -180, 1'b1},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_WRITE,       32'd43,       360, 1'b1, 1023,  360, 1'b1},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_WRITE,       32'd44,        -1, 1'b1,  204,   -1, 1'b1},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_TICK,        32'd61,         0, 1'b1,  204,   -1, 1'b0},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_TICK,        32'd62,         0, 1'b0,    0,    0, 1'b0},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_TICK,        32'hFFFF_FFFF,  0, 1'b0,    0,    0, 1'b0},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_TICK,        32'd5,          0, 1'b0,    0,    0, 1'b0},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_UNKNOWN,     32'hFFFF_FFFF, -1, 1'b0,    0,    0, 1'b0},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_PHASE_RESET, 32'd0,          0, 1'b0,    0,    0, 1'b0},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_TICK,        32'd40,         0, 1'b1,  614,   90, 1'b1},
    '{ROW_REG,  CFG_SLEW_LIMIT,    OP_TICK,        32'd0,         10, 1'b0,    0,    0, 1'b0},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_WRITE,       32'd100,      180, 1'b0,    0,    0, 1'b0},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_WRITE,       32'd100100,  -180, 1'b0,    0,    0, 1'b0},
    '{ROW_REG,  CFG_SLEW_LIMIT,    OP_TICK,        32'd0,      10000, 1'b0,    0,    0, 1'b0},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_WRITE,       32'hFFFF_FFF0, 360, 1'b0,   0,    0, 1'b0},
    '{ROW_REG,  CFG_MODE,          OP_TICK,        32'd0,          2, 1'b0,    0,    0, 1'b0},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_TICK,        32'd1000,       0, 1'b0,    0,    0, 1'b0},
    '{ROW_REG,  CFG_MODE,          OP_TICK,        32'd0,          1, 1'b0,    0,    0, 1'b0},
    '{ROW_REG,  CFG_SAMPLE_PERIOD, OP_TICK,        32'd0,          0, 1'b0,    0,    0, 1'b0},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_TICK,        32'd1001,       0, 1'b0,    0,    0, 1'b0},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_TICK,        32'd1001,       0, 1'b0,    0,    0, 1'b0},
    '{ROW_REG,  CFG_AMPLITUDE,     OP_TICK,        32'd0,         90, 1'b0,    0,    0, 1'b0},
    '{ROW_REG,  CFG_CENTER_OFFSET, OP_TICK,        32'd0,         90, 1'b0,    0,    0, 1'b0},
    '{ROW_REG,  CFG_TRIM,          OP_TICK,        32'd0,        -90, 1'b0,    0,    0, 1'b0},
    '{ROW_REG,  CFG_START_PHASE,   OP_TICK,        32'd0,      16384, 1'b0,    0,    0, 1'b0},
    '{ROW_REG,  CFG_PERIOD,        OP_TICK,        32'd0,          1, 1'b0,    0,    0, 1'b0},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_TICK,        32'd1002,       0, 1'b0,    0,    0, 1'b0},
    '{ROW_WORD, CFG_AMPLITUDE,     OP_TICK,        32'd1003,       0, 1'b0,    0,    0, 1'b0}
  };

  servo_sine_oscillator_top u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .in_opcode_i          (in_opcode_i),
    .in_now_ms_i          (in_now_ms_i),
    .in_target_position_i (in_target_position_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_duty_o           (out_duty_o),
    .out_position_o       (out_position_o),
    .out_written_o        (out_written_o),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_data_i           (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Q16 sine of k/QTR of a quarter turn, from an 8-term Taylor series in Q30
  function automatic int taylor_sine(int unsigned k);
    longint unsigned x, s, t;
    x = (64'(k) * PI_HALF_Q30) / QTR;
    s = x;
    t = x;
    for (int n = 1; n <= 7; n++) begin
      t = (((t * x) >> 30) * x) >> 30;
      t = t / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) s = s - t;
      else s = s + t;
    end
    return int'((s + 64'd8192) >> 14);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  // slew toward the target, clamp with trim and convert to a duty value
  task automatic move_servo(input int target, input logic [31:0] now);
    logic [31:0]     el;
    longint unsigned lim;
    int              d, ad, a;
    if (slew_dps > 0) begin
      el = now - last_cmd_ms;
      lim = (64'(el) * 64'(slew_dps)) / 1000;
      d = target - pos_deg;
      ad = (d < 0) ? -d : d;
      if (lim < 1) lim = 1;
      if (64'(ad) > lim) pos_deg += (d < 0) ? -int'(lim) : int'(lim);
      else pos_deg = target;
    end else begin
      pos_deg = target;
    end
    last_cmd_ms = now;
    a = pos_deg + trim_deg;
    if (a < 0) a = 0;
    if (a > 180) a = 180;
    duty_held = 10'((4 * a + 180) * 8191 / 7200);
  endtask

  task automatic predict_servo(input logic [1:0] op, input logic [31:0] now, input int tgt,
                               output servo_word_t w);
    logic [31:0] el, ph;
    int unsigned sp, ns;
    int          idx, sv, r, p;
    longint      prod, mag;
    w.written = 1'b0;
    if (op == OP_TICK) begin
      el = now - last_sample_ms;
      if (el > sample_ms) begin
        sp = (sample_ms == 0) ? 1 : sample_ms;
        ns = period_ms / sp;
        last_sample_ms = now;
        samples_taken++;
        if (!mode_cfg[MODE_PAUSE]) begin
          ph = phase_acc + (32'(start_turn) << 16);
          idx = int'(ph[29:22]);
          sv = ph[30] ? sine_q16[QTR - idx] : sine_q16[idx];
          if (ph[31]) sv = -sv;
          prod = longint'(amp_deg) * sv;
          mag = (prod < 0) ? -prod : prod;
          r = int'((mag + 32768) >> 16);
          p = ((prod < 0) ? -r : r) + ofs_deg;
          if (mode_cfg[MODE_REVERSE]) p = -p;
          move_servo(p + 90, now);
          w.written = 1'b1;
        end else begin
          samples_paused++;
        end
        if (ns == 0) ns = 1;
        phase_acc = phase_acc + 32'(64'h1_0000_0000 / ns);
      end
    end else if (op == OP_WRITE) begin
      move_servo(tgt, now);
      w.written = 1'b1;
      direct_writes++;
    end else if (op == OP_PHASE_RESET) begin
      phase_acc = '0;
      phase_resets++;
    end
    w.duty = duty_held;
    w.pos = 10'(pos_deg);
  endtask

  // present one word and hold it until accepted; valid is left high
  task automatic send_word(input logic [1:0] op, input logic [31:0] now, input int tgt,
                           input bit given, input servo_word_t given_w);
    servo_word_t w;
    in_valid_i <= 1'b1;
    in_opcode_i <= op;
    in_now_ms_i <= now;
    in_target_position_i <= 10'(tgt);
    do @(posedge clk_i); while (in_stall_o);
    predict_servo(op, now, tgt, w);
    servo_q.push_back(given ? given_w : w);
    words_sent++;
  endtask

  task automatic sender_gap(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (servo_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // leaves the write enable high; the caller drops it
  task automatic write_reg(input cfg_idx_e idx, input int value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= 16'(value);
    @(posedge clk_i);
    case (idx)
      CFG_AMPLITUDE:     amp_deg = value & 32'h7F;
      CFG_CENTER_OFFSET: ofs_deg = int'($signed(value[7:0]));
      CFG_PERIOD:        period_ms = value & 32'hFFFF;
      CFG_SAMPLE_PERIOD: sample_ms = value & 32'h3FF;
      CFG_START_PHASE:   start_turn = value & 32'hFFFF;
      CFG_TRIM:          trim_deg = int'($signed(value[7:0]));
      CFG_SLEW_LIMIT:    slew_dps = value & 32'h3FFF;
      default:           mode_cfg = 2'(value);
    endcase
  endtask

  task automatic load_settings(input servo_cfg_t c);
    drain_results();
    write_reg(CFG_AMPLITUDE, c.amp);
    write_reg(CFG_CENTER_OFFSET, c.ofs);
    write_reg(CFG_PERIOD, c.period);
    write_reg(CFG_SAMPLE_PERIOD, c.spacing);
    write_reg(CFG_START_PHASE, c.phase0);
    write_reg(CFG_TRIM, c.trim);
    write_reg(CFG_SLEW_LIMIT, c.slew);
    write_reg(CFG_MODE, c.mode);
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  function automatic servo_cfg_t random_settings();
    servo_cfg_t c;
    c.amp = $urandom_range(0, 90);
    c.ofs = int'($urandom_range(0, 180)) - 90;
    case ($urandom_range(0, 2))
      0:       c.period = $urandom_range(1, 200);
      1:       c.period = $urandom_range(1, 5000);
      default: c.period = $urandom_range(1, 65535);
    endcase
    case ($urandom_range(0, 3))
      0:       c.spacing = $urandom_range(0, 3);
      1:       c.spacing = $urandom_range(1, 40);
      2:       c.spacing = $urandom_range(1, 200);
      default: c.spacing = $urandom_range(1, 1000);
    endcase
    c.phase0 = $urandom_range(0, 65535);
    c.trim = int'($urandom_range(0, 180)) - 90;
    case ($urandom_range(0, 3))
      0, 1:    c.slew = 0;
      2:       c.slew = $urandom_range(1, 50);
      default: c.slew = $urandom_range(1, 10000);
    endcase
    c.mode = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : $urandom_range(0, 1);
    return c;
  endfunction

  // mostly time-ordered ticks and writes; a few time jumps and odd opcodes
  task automatic random_word();
    int          pick, tgt;
    logic [1:0]  op;
    servo_word_t none;
    none = '{default: '0};
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      op = OP_TICK;
      clock_ms += $urandom_range(0, 2 * sample_ms + 3);
    end else if (pick < 84) begin
      op = OP_WRITE;
      clock_ms += $urandom_range(0, 300);
    end else if (pick < 91) begin
      op = OP_PHASE_RESET;
    end else if (pick < 95) begin
      op = OP_UNKNOWN;
    end else begin
      op = 2'($urandom_range(0, 3));
      clock_ms = $urandom();
    end
    case ($urandom_range(0, 9))
      0:       tgt = -180;
      1:       tgt = 360;
      default: tgt = int'($urandom_range(0, 540)) - 180;
    endcase
    send_word(op, clock_ms, tgt, 1'b0, none);
  endtask

  // receiver: stall style is redrawn whenever its hold counter runs out
  always @(posedge clk_i) begin
    if (rx_hold == 0) begin
      rx_style <= rx_style_e'($urandom_range(0, 3));
      rx_hold <= $urandom_range(50, 400);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    case (rx_style)
      RX_OPEN:     out_stall_i <= 1'b0;
      RX_RANDOM:   out_stall_i <= ($urandom_range(0, 2) == 0);
      RX_PERIODIC: out_stall_i <= (rx_tick[2:0] == 3'd5);
      default:     out_stall_i <= (rx_tick < 4'd11);
    endcase
    rx_tick <= rx_tick + 4'd1;
  end

  always @(posedge clk_i) begin
    servo_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (servo_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result duty %0d position %0d written %0b",
                                  out_duty_o, out_position_o, out_written_o));
      end else begin
        want = servo_q.pop_front();
        results_checked++;
        if (out_duty_o !== want.duty)
          report_mismatch($sformatf("duty got %0d expected %0d", out_duty_o, want.duty));
        if (out_position_o !== want.pos)
          report_mismatch($sformatf("position got %0d expected %0d",
                                    out_position_o, want.pos));
        if (out_written_o !== want.written)
          report_mismatch($sformatf("written got %0b expected %0b",
                                    out_written_o, want.written));
      end
    end
  end

  initial begin
    #1_500_000;
    $display("run timed out with %0d results outstanding", servo_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    servo_cfg_t  cfg;
    servo_word_t given_w;
    int          burst_left;
    bit          no_gaps;
    for (int k = 0; k <= QTR; k++) sine_q16[k] = taylor_sine(k);
    amp_deg = AMP_RESET;
    ofs_deg = 0;
    period_ms = PERIOD_RESET;
    sample_ms = SPER_RESET;
    start_turn = 0;
    trim_deg = 0;
    slew_dps = 0;
    mode_cfg = '0;
    phase_acc = '0;
    last_sample_ms = '0;
    last_cmd_ms = '0;
    pos_deg = POS_RESET;
    duty_held = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        drain_results();
        write_reg(plan[i].idx, plan[i].val);
        cfg_we_i <= 1'b0;
      end else begin
        given_w.duty = 10'(plan[i].duty);
        given_w.pos = 10'(plan[i].pos);
        given_w.written = plan[i].wr;
        send_word(plan[i].op, plan[i].now, plan[i].val, plan[i].given, given_w);
        if ($urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 8));
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) cfg = '{90, 90, 65535, 1000, 65535, 90, 10000, 3};
      else if (ph == 1) cfg = '{0, -90, 1, 1, 0, -90, 0, 0};
      else cfg = random_settings();
      load_settings(cfg);
      no_gaps = (ph % 3 == 2);
      burst_left = $urandom_range(1, 12);
      for (int n = 0; n < 50; n++) begin
        random_word();
        burst_left--;
        // now and then hold off until every result is back
        if ($urandom_range(0, 39) == 0) begin
          drain_results();
        end else if (!no_gaps && burst_left <= 0) begin
          sender_gap($urandom_range(1, 20));
          burst_left = $urandom_range(1, 12);
        end
      end
    end

    in_valid_i <= 1'b0;
    while (servo_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Covered %0d words: %0d sine samples (%0d paused), %0d direct writes, %0d phase resets",
             words_sent, samples_taken, samples_paused, direct_writes, phase_resets);
    $display("over %0d full register loads plus directed writes; %0d results checked, %0d errors",
             settings_loaded, results_checked, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
